@@ rtl/ckhb_pkg.sv @@
`timescale 1ns / 1ps

package ckhb_pkg;

  // Window and hash geometry
  localparam int unsigned MAX_KMER = 64;
  localparam int unsigned KMER_W   = $clog2(MAX_KMER + 1);
  localparam int unsigned WIN_AW   = $clog2(MAX_KMER);
  localparam int unsigned HASH_W   = 64;
  localparam int unsigned ROT_W    = $clog2(HASH_W);

  // Bloom filter geometry
  localparam int unsigned FILTER_BITS = 1048576;
  localparam int unsigned SIZE_W      = $clog2(FILTER_BITS + 1);
  localparam int unsigned IDX_W       = 20;
  localparam int unsigned ROW_W       = 64;
  localparam int unsigned BIT_AW      = $clog2(ROW_W);
  localparam int unsigned BLOOM_ROWS  = FILTER_BITS / ROW_W;
  localparam int unsigned ROW_AW      = $clog2(BLOOM_ROWS);

  // Remainder unit: DIV_RADIX dividend bits per cycle
  localparam int unsigned DIV_RADIX = 4;
  localparam int unsigned DIV_STEPS = HASH_W / DIV_RADIX;
  localparam int unsigned DIV_CNT_W = $clog2(DIV_STEPS);

  // Configuration port
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 64;

  localparam logic [CFG_IDX_W-1:0] REG_KMER_LEN    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FILTER_SIZE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_A      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_C      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_G      = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SEED_T      = 3'd5;

  localparam logic [KMER_W-1:0] KMER_RESET        = 7'd28;
  localparam logic [SIZE_W-1:0] FILTER_SIZE_RESET = SIZE_W'(FILTER_BITS);

  typedef logic [HASH_W-1:0] hash_t;

  typedef enum logic [7:0] {
    ST_CLEAR    = 8'b0000_0001,
    ST_IDLE     = 8'b0000_0010,
    ST_HASH     = 8'b0000_0100,
    ST_CANON    = 8'b0000_1000,
    ST_DIV      = 8'b0001_0000,
    ST_BLOOM_RD = 8'b0010_0000,
    ST_BLOOM_WR = 8'b0100_0000,
    ST_PUSH     = 8'b1000_0000
  } state_e;

  // Rotate left by amt, amt taken modulo HASH_W
  function automatic hash_t rotl(input hash_t x, input logic [ROT_W-1:0] amt);
    logic [ROT_W:0] inv;
    inv = (ROT_W + 1)'(HASH_W) - {1'b0, amt};
    return (x << amt) | (x >> inv);
  endfunction

  function automatic hash_t rotr1(input hash_t x);
    return {x[0], x[HASH_W-1:1]};
  endfunction

  // Clamp the window length into 1..MAX_KMER
  function automatic logic [KMER_W-1:0] eff_kmer(input logic [KMER_W-1:0] k);
    logic [KMER_W-1:0] r;
    r = k;
    if (k == '0) r = KMER_W'(1);
    else if (k > KMER_W'(MAX_KMER)) r = KMER_W'(MAX_KMER);
    return r;
  endfunction

  // Clamp the modulus into 1..FILTER_BITS
  function automatic logic [SIZE_W-1:0] eff_size(input logic [SIZE_W-1:0] s);
    logic [SIZE_W-1:0] r;
    r = s;
    if (s == '0) r = SIZE_W'(1);
    else if (s > SIZE_W'(FILTER_BITS)) r = SIZE_W'(FILTER_BITS);
    return r;
  endfunction

endpackage

@@ rtl/ckhb_ram.sv @@
`timescale 1ns / 1ps

module ckhb_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/canonical_kmer_hash_bloom_insert.sv @@
`timescale 1ns / 1ps

// Canonical k-mer rolling hash with Bloom filter insertion.
//
// Input channel (in_valid_i / in_ready_o): one request per base, a two-bit
// base code and a flag marking the first base of a sequence. Output channel
// (out_valid_o / out_ready_i): one request per base once kmer_len bases of the
// current sequence are in, carrying the canonical hash and its filter index.
// Configuration: cfg_we_i writes register cfg_idx_i with cfg_wdata_i at once.
//
// Steps: a base that completes no window passes accept and hash update.
// A base that yields a result passes, from accept to out_valid_o, the hash
// update, the minimum select, the remainder unit (4 dividend bits per
// cycle), a read of the Bloom filter row, then its write, which loads the
// output register when it is free. The block takes no new base until it
// is through with the last one.
//
// Reset: registers return to their reset values, then a clearing pass zeroes
// the filter memory, one 64-bit row a cycle, all 16384 rows, with in_ready_o
// low. Configuration writes are taken during that pass.
// Receiver stall: the result waits in the output register; the block keeps
// taking bases and stalls before loading a second result.

module canonical_kmer_hash_bloom_insert
  import ckhb_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // base requests
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  logic [1:0]            base_i,
  input  logic                  seq_start_i,
  // result requests
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output logic [HASH_W-1:0]     canonical_hash_o,
  output logic [IDX_W-1:0]      bit_index_o,
  // configuration writes
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  state_e state_q, state_d;

  // Configuration registers
  logic [KMER_W-1:0] kmer_len_q;
  logic [SIZE_W-1:0] filter_size_q;
  hash_t             seed_q [4];
  logic              restart;

  // Sequence state
  hash_t             fwd_q, fwd_d;
  hash_t             rev_q, rev_d;
  logic [KMER_W-1:0] fill_q, fill_d;
  logic [WIN_AW-1:0] wptr_q;
  logic [1:0]        base_q;
  logic              start_q;
  logic              emit;

  // Remainder unit
  hash_t               num_q;
  logic [SIZE_W-1:0]   rem_q, rem_d;
  logic [SIZE_W-1:0]   den_q;
  logic [DIV_CNT_W-1:0] div_cnt_q;

  // Clearing pass and output register
  logic [ROW_AW-1:0] clr_cnt_q;
  hash_t             canon_q;
  logic              out_valid_q;
  hash_t             out_hash_q;
  logic [IDX_W-1:0]  out_idx_q;
  logic              out_free;

  // Memories
  logic [1:0]        win_rdata;
  logic [WIN_AW-1:0] win_raddr;
  logic              bloom_we;
  logic [ROW_AW-1:0] bloom_waddr;
  logic [ROW_AW-1:0] bloom_row;
  logic [ROW_W-1:0]  bloom_wdata;
  logic [ROW_W-1:0]  bloom_rdata;

  logic [KMER_W-1:0] k;
  assign k = eff_kmer(kmer_len_q);

  assign in_ready_o = (state_q == ST_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;

  // ---------------------------------------------------------------------
  // Base window: circular buffer. Read the base leaving the window at
  // accept; write the new base in the hash cycle, so the two never meet.
  // ---------------------------------------------------------------------
  assign win_raddr = wptr_q - k[WIN_AW-1:0];

  ckhb_ram #(
    .WIDTH(2),
    .DEPTH(MAX_KMER)
  ) u_win_ram (
    .clk_i  (clk_i),
    .we_i   (state_q == ST_HASH),
    .waddr_i(wptr_q),
    .wdata_i(base_q),
    .raddr_i(win_raddr),
    .rdata_o(win_rdata)
  );

  // ---------------------------------------------------------------------
  // Rolling hash update. A sequence start clears fill and both hashes
  // before the base goes in.
  // ---------------------------------------------------------------------
  always_comb begin
    logic [KMER_W-1:0] fill_eff;
    hash_t             fwd_eff;
    hash_t             rev_eff;
    logic              steady;
    logic [1:0]        comp_b;
    logic [ROT_W-1:0]  rev_amt;
    fill_eff = start_q ? '0 : fill_q;
    fwd_eff  = start_q ? '0 : fwd_q;
    rev_eff  = start_q ? '0 : rev_q;
    steady   = (fill_eff >= k);
    comp_b   = ~base_q;
    rev_amt  = steady ? ROT_W'(k - KMER_W'(1)) : ROT_W'(fill_eff);

    fwd_d = rotl(fwd_eff, ROT_W'(1)) ^ seed_q[base_q];
    if (steady) begin
      fwd_d  = fwd_d ^ rotl(seed_q[win_rdata], k[ROT_W-1:0]);
      rev_d  = rotr1(rev_eff) ^ rotr1(seed_q[~win_rdata]) ^ rotl(seed_q[comp_b], rev_amt);
      fill_d = k;
    end else begin
      rev_d  = rev_eff ^ rotl(seed_q[comp_b], rev_amt);
      fill_d = fill_eff + KMER_W'(1);
    end
    emit = steady || (fill_d == k);
  end

  // ---------------------------------------------------------------------
  // Remainder unit: restoring, DIV_RADIX dividend bits per cycle
  // ---------------------------------------------------------------------
  always_comb begin
    logic [SIZE_W-1:0] t;
    t = rem_q;
    for (int j = 0; j < DIV_RADIX; j++) begin
      t = {t[SIZE_W-2:0], num_q[HASH_W-1-j]};
      if (t >= den_q) t = t - den_q;
    end
    rem_d = t;
  end

  // ---------------------------------------------------------------------
  // Bloom filter: one read-modify-write per result; items are serialized,
  // so a row read never overlaps a pending write to the same row.
  // ---------------------------------------------------------------------
  assign bloom_row   = rem_q[IDX_W-1:BIT_AW];
  assign bloom_we    = (state_q == ST_CLEAR) || (state_q == ST_BLOOM_WR);
  assign bloom_waddr = (state_q == ST_CLEAR) ? clr_cnt_q : bloom_row;
  assign bloom_wdata = (state_q == ST_CLEAR) ? '0
                     : bloom_rdata | (ROW_W'(1) << rem_q[BIT_AW-1:0]);

  ckhb_ram #(
    .WIDTH(ROW_W),
    .DEPTH(BLOOM_ROWS)
  ) u_bloom_ram (
    .clk_i  (clk_i),
    .we_i   (bloom_we),
    .waddr_i(bloom_waddr),
    .wdata_i(bloom_wdata),
    .raddr_i(bloom_row),
    .rdata_o(bloom_rdata)
  );

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == ROW_AW'(BLOOM_ROWS - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_HASH;
      end
      ST_HASH: begin
        state_d = emit ? ST_CANON : ST_IDLE;
      end
      ST_CANON: begin
        state_d = ST_DIV;
      end
      ST_DIV: begin
        if (div_cnt_q == DIV_CNT_W'(DIV_STEPS - 1)) state_d = ST_BLOOM_RD;
      end
      ST_BLOOM_RD: begin
        state_d = ST_BLOOM_WR;
      end
      ST_BLOOM_WR: begin
        state_d = out_free ? ST_IDLE : ST_PUSH;
      end
      ST_PUSH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      clr_cnt_q <= '0;
      div_cnt_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_cnt_q <= clr_cnt_q + ROW_AW'(1);
      if (state_q == ST_CANON) div_cnt_q <= '0;
      else if (state_q == ST_DIV) div_cnt_q <= div_cnt_q + DIV_CNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Configuration registers; a window length or seed write restarts the
  // sequence.
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kmer_len_q    <= KMER_RESET;
      filter_size_q <= FILTER_SIZE_RESET;
      for (int i = 0; i < 4; i++) seed_q[i] <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_KMER_LEN:    kmer_len_q    <= cfg_wdata_i[KMER_W-1:0];
        REG_FILTER_SIZE: filter_size_q <= cfg_wdata_i[SIZE_W-1:0];
        REG_SEED_A, REG_SEED_C, REG_SEED_G, REG_SEED_T:
          seed_q[2'(cfg_idx_i - REG_SEED_A)] <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_comb begin
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i) inside
        REG_KMER_LEN, REG_SEED_A, REG_SEED_C, REG_SEED_G, REG_SEED_T: restart = 1'b1;
        default: restart = 1'b0;
      endcase
    end
  end

  // Sequence state: hashes, fill and window pointer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_q  <= '0;
      rev_q  <= '0;
      fill_q <= '0;
      wptr_q <= '0;
    end else if (restart) begin
      fwd_q  <= '0;
      rev_q  <= '0;
      fill_q <= '0;
    end else if (state_q == ST_HASH) begin
      fwd_q  <= fwd_d;
      rev_q  <= rev_d;
      fill_q <= fill_d;
      wptr_q <= wptr_q + WIN_AW'(1);
    end
  end

  // Payload registers: hold the accepted base, the divider operands
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      base_q  <= base_i;
      start_q <= seq_start_i;
    end
    if (state_q == ST_CANON) begin
      canon_q <= (rev_q < fwd_q) ? rev_q : fwd_q;
      num_q   <= (rev_q < fwd_q) ? rev_q : fwd_q;
      rem_q   <= '0;
      den_q   <= eff_size(filter_size_q);
    end else if (state_q == ST_DIV) begin
      num_q <= num_q << DIV_RADIX;
      rem_q <= rem_d;
    end
  end

  // Output register: load when free, drop on handshake
  logic out_load;
  assign out_load = ((state_q == ST_BLOOM_WR) || (state_q == ST_PUSH)) && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_hash_q <= canon_q;
      out_idx_q  <= rem_q[IDX_W-1:0];
    end
  end

  assign out_valid_o      = out_valid_q;
  assign canonical_hash_o = out_hash_q;
  assign bit_index_o      = out_idx_q;

endmodule

@@ rtl/ckhb_checker.sv @@
`timescale 1ns / 1ps

module ckhb_checker
  import ckhb_pkg::*;
(
  input logic                  clk_i,
  input logic                  rst_ni,
  input logic                  in_valid_i,
  input logic                  in_ready_o,
  input logic                  out_valid_o,
  input logic                  out_ready_i,
  input logic [HASH_W-1:0]     canonical_hash_o,
  input logic [IDX_W-1:0]      bit_index_o
);

  // A pending result holds until taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=>
      out_valid_o && $stable(canonical_hash_o) && $stable(bit_index_o))
    else $error("result changed or dropped while stalled");

  // One base at a time: busy right after an accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("second base taken back to back");

  // A result never appears in the cycle after a base is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_valid_i && in_ready_o))
    else $error("result appeared too early");

  // The remainder never exceeds its dividend
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (HASH_W'(bit_index_o) <= canonical_hash_o))
    else $error("bit index above canonical hash");

endmodule

bind canonical_kmer_hash_bloom_insert ckhb_checker u_ckhb_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .canonical_hash_o(canonical_hash_o),
  .bit_index_o     (bit_index_o)
);
